### rtl/core/rshm_pkg.sv
// Shared types and constants of the ring/sector hit matcher.
// No dependencies; imported by rshm_front, rshm_back and ring_sector_hit_matcher.
package rshm_pkg;

  localparam int ChanW   = 8;
  localparam int EnergyW = 24;
  localparam int TimeW   = 32;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_MATCH = 2'd2;

  localparam logic [EnergyW-1:0] WINDOW_RESET = {EnergyW{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MATCH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [ChanW-1:0]        hit_channel;
    logic [EnergyW-1:0]      hit_energy;
    logic signed [TimeW-1:0] hit_time;
  } rshm_in_t;

  typedef struct packed {
    logic             match_found;
    logic [ChanW-1:0] sector_channel;
    logic             table_overflow;
  } rshm_out_t;

  typedef struct packed {
    op_e                     op;
    logic [ChanW-1:0]        hit_channel;
    logic [EnergyW-1:0]      hit_energy;
    logic signed [TimeW-1:0] hit_time;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0]        channel;
    logic [EnergyW-1:0]      energy;
    logic signed [TimeW-1:0] time_stamp;
  } slot_t;

endpackage

### rtl/core/rshm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rshm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/rshm_front.sv
// Front end: accepts input items, decodes the action and queues commands.
// Depends on rshm_pkg.
module rshm_front import rshm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rshm_in_t in_data_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t       queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_new;
  logic       push;

  always_comb begin
    cmd_new.hit_channel = in_data_i.hit_channel;
    cmd_new.hit_energy  = in_data_i.hit_energy;
    cmd_new.hit_time    = in_data_i.hit_time;
    unique case (in_data_i.action)
      ACT_CLEAR: cmd_new.op = OP_CLEAR;
      ACT_LOAD:  cmd_new.op = OP_LOAD;
      ACT_MATCH: cmd_new.op = OP_MATCH;
      default:   cmd_new.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    unique case ({push, cmd_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### rtl/core/rshm_back.sv
// Back end: executes queued commands on the sector table and holds the result.
// Depends on rshm_pkg and rshm_ram.
module rshm_back import rshm_pkg::*; #(
  parameter int HIT_SLOTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic [EnergyW-1:0] win_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rshm_out_t          out_data_o
);

  localparam int IdxW = $clog2(HIT_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HIT_SLOTS - 1);
  localparam int SlotW = $bits(slot_t);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  cmd_t                   cur_q, cur_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   iss_q, iss_d;
  logic [HIT_SLOTS-1:0]   valid_q, valid_d;
  logic                   out_valid_q, out_valid_d;
  rshm_out_t              out_q, out_d;
  logic                   best_clr;

  logic                   ram_we, ram_re;
  slot_t                  ram_wdata, rd_slot;
  logic [SlotW-1:0]       ram_rdata;

  logic                   p1_vld_q, p1_last_q, p1_sv_q;
  logic [IdxW-1:0]        p1_idx_q;
  logic                   p2_vld_q, p2_last_q, p2_sv_q;
  logic [IdxW-1:0]        p2_idx_q;
  logic [ChanW-1:0]       p2_ch_q;
  logic [EnergyW-1:0]     p2_de_q;
  logic [TimeW:0]         p2_dt_q;

  logic                   best_found_q;
  logic [IdxW-1:0]        best_idx_q;
  logic [ChanW-1:0]       best_ch_q;
  logic [TimeW:0]         best_dt_q;

  logic [EnergyW:0]       e_ab;
  logic [EnergyW-1:0]     e_ba, de;
  logic [TimeW:0]         t_ab, t_ba, dt;
  logic                   cand, better;

  assign ram_wdata.channel    = cur_q.hit_channel;
  assign ram_wdata.energy     = cur_q.hit_energy;
  assign ram_wdata.time_stamp = cur_q.hit_time;
  assign ram_re               = (state_q == ST_SCAN) && iss_q;

  rshm_ram #(
    .WIDTH(SlotW),
    .DEPTH(HIT_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    best_clr    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          idx_d     = '0;
          out_d     = '0;
          unique case (cmd_i.op)
            OP_CLEAR: begin
              valid_d     = '0;
              out_valid_d = 1'b1;
            end
            OP_LOAD: begin
              state_d = ST_LOAD;
            end
            OP_MATCH: begin
              state_d  = ST_SCAN;
              iss_d    = 1'b1;
              best_clr = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_LOAD: begin
        priority if (!valid_q[idx_q]) begin
          ram_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end else if (idx_q == LastIdx) begin
          out_d.table_overflow = 1'b1;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          if (idx_q == LastIdx) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (p2_vld_q && p2_last_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_d.match_found    = best_found_q;
        out_d.sector_channel = best_found_q ? best_ch_q : '0;
        if (best_found_q) begin
          valid_d[best_idx_q] = 1'b0;
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // absolute differences, both directions in parallel
  assign e_ab = {1'b0, rd_slot.energy} - {1'b0, cur_q.hit_energy};
  assign e_ba = cur_q.hit_energy - rd_slot.energy;
  assign de   = e_ab[EnergyW] ? e_ba : e_ab[EnergyW-1:0];
  assign t_ab = {rd_slot.time_stamp[TimeW-1], rd_slot.time_stamp}
              - {cur_q.hit_time[TimeW-1], cur_q.hit_time};
  assign t_ba = {cur_q.hit_time[TimeW-1], cur_q.hit_time}
              - {rd_slot.time_stamp[TimeW-1], rd_slot.time_stamp};
  assign dt   = t_ab[TimeW] ? t_ba : t_ab;

  assign cand   = p2_vld_q && p2_sv_q && (p2_de_q < win_i);
  assign better = !best_found_q || (p2_dt_q < best_dt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      iss_q        <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      iss_q       <= iss_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      p1_vld_q    <= ram_re;
      p2_vld_q    <= p1_vld_q;
      if (best_clr) begin
        best_found_q <= 1'b0;
      end else if (cand && better) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    out_q     <= out_d;
    p1_last_q <= (idx_q == LastIdx);
    p1_sv_q   <= valid_q[idx_q];
    p1_idx_q  <= idx_q;
    p2_last_q <= p1_last_q;
    p2_sv_q   <= p1_sv_q;
    p2_idx_q  <= p1_idx_q;
    p2_ch_q   <= rd_slot.channel;
    p2_de_q   <= de;
    p2_dt_q   <= dt;
    if (cand && better) begin
      best_idx_q <= p2_idx_q;
      best_ch_q  <= p2_ch_q;
      best_dt_q  <= p2_dt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !out_valid_q)
    else $error("command taken while result pending");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.match_found && out_q.table_overflow))
    else $error("match and overflow in one result");
  a_no_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.match_found) |-> (out_q.sector_channel == '0))
    else $error("channel reported without match");
  a_best_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && best_found_q) |-> valid_q[best_idx_q])
    else $error("winning slot not valid");
  a_pipe_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |-> (state_q == ST_SCAN))
    else $error("scan pipeline active outside scan");
`endif

endmodule

### rtl/core/ring_sector_hit_matcher.sv
// Ring/sector hit matcher. Clear, load and match items enter a two-entry
// command queue and each yields one result. A clear or unused action is
// answered directly from idle; a load steps over occupied slots and stores
// the hit in the lowest free one, reporting an overflow when the table is
// full; a match walks over the sector table through the single read port of
// the slot RAM, passes a two-stage compare pipeline and removes the winner.
// The back end takes the next command in the cycle after the result transfers.
// Depends on rshm_pkg, rshm_front, rshm_back and rshm_ram.
module ring_sector_hit_matcher import rshm_pkg::*; #(
  parameter int HIT_SLOTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rshm_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rshm_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [EnergyW-1:0] cfg_wdata_i
);

  logic [EnergyW-1:0] win_q;
  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  rshm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  rshm_back #(
    .HIT_SLOTS(HIT_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .win_i      (win_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
